// ===== hdl/psd3_pkg.sv =====
// Shared types and constants for the point-to-segment distance unit.
package psd3_pkg;

    localparam int DIST_W     = 17;
    localparam int SQRT_STEPS = DIST_W;

    typedef enum logic [1:0] {
        REGION_BEFORE = 2'd0,
        REGION_BEYOND = 2'd1,
        REGION_INSIDE = 2'd2
    } region_t;

endpackage

// ===== hdl/point_segment_distance_3d_unit.sv =====
// Pipelined point-to-segment distance in three dimensions.
//
//   channel   signals                                         direction
//   query     query_valid, query_stall, start_*, end_*, query_*   in
//   result    result_valid, result_stall, distance, region,      out
//             degenerate
//
// One query enters per cycle while query_stall is low; six stages of
// differences, products, sums, classification and a split wide multiply,
// then one stage per result bit of a shift-and-add square root of num/den.
// Reset clears only the valid bits. Each stage holds while its successor
// is full and stalled, so bubbles close up and nothing is lost or repeated.
module point_segment_distance_3d_unit
    import psd3_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  query_valid,
    output logic                  query_stall,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] start_z,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [COORD_BITS-1:0] end_z,
    input  logic [COORD_BITS-1:0] query_x,
    input  logic [COORD_BITS-1:0] query_y,
    input  logic [COORD_BITS-1:0] query_z,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [DIST_W-1:0]     distance,
    output logic [1:0]            region,
    output logic                  degenerate
);

    localparam int DW = COORD_BITS + 1;       // coordinate difference
    localparam int MW = 2 * DW;               // one product of differences
    localparam int PW = 2 * COORD_BITS + 4;   // sum of three products
    localparam int H  = PW / 2;               // half word for the split multiply
    localparam int NW = 2 * PW;               // full product
    localparam int EW = NW + 40;              // root step arithmetic
    localparam int NSTG = 6 + SQRT_STEPS;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || !result_stall;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign query_stall = !adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= query_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 1: differences d = B - A, w = P - A, e = P - B.
    logic signed [DW-1:0] d1_reg [3];
    logic signed [DW-1:0] w1_reg [3];
    logic signed [DW-1:0] e1_reg [3];
    logic [COORD_BITS-1:0] ca [3];
    logic [COORD_BITS-1:0] cb [3];
    logic [COORD_BITS-1:0] cp [3];

    assign ca = '{start_x, start_y, start_z};
    assign cb = '{end_x, end_y, end_z};
    assign cp = '{query_x, query_y, query_z};

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i] <= $signed({cb[i][COORD_BITS-1], cb[i]})
                           - $signed({ca[i][COORD_BITS-1], ca[i]});
                w1_reg[i] <= $signed({cp[i][COORD_BITS-1], cp[i]})
                           - $signed({ca[i][COORD_BITS-1], ca[i]});
                e1_reg[i] <= $signed({cp[i][COORD_BITS-1], cp[i]})
                           - $signed({cb[i][COORD_BITS-1], cb[i]});
            end
        end
    end

    // Stage 2: per-axis products.
    logic signed [MW-1:0] wd2_reg [3];
    logic signed [MW-1:0] dd2_reg [3];
    logic signed [MW-1:0] ww2_reg [3];
    logic signed [MW-1:0] ee2_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                wd2_reg[i] <= MW'(w1_reg[i]) * MW'(d1_reg[i]);
                dd2_reg[i] <= MW'(d1_reg[i]) * MW'(d1_reg[i]);
                ww2_reg[i] <= MW'(w1_reg[i]) * MW'(w1_reg[i]);
                ee2_reg[i] <= MW'(e1_reg[i]) * MW'(e1_reg[i]);
            end
        end
    end

    // Stage 3: dot products.
    logic signed [PW-1:0] t3_reg;
    logic [PW-1:0]        len3_reg;
    logic [PW-1:0]        ww3_reg;
    logic [PW-1:0]        ee3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            t3_reg   <= PW'(wd2_reg[0]) + PW'(wd2_reg[1]) + PW'(wd2_reg[2]);
            len3_reg <= PW'(dd2_reg[0]) + PW'(dd2_reg[1]) + PW'(dd2_reg[2]);
            ww3_reg  <= PW'(ww2_reg[0]) + PW'(ww2_reg[1]) + PW'(ww2_reg[2]);
            ee3_reg  <= PW'(ee2_reg[0]) + PW'(ee2_reg[1]) + PW'(ee2_reg[2]);
        end
    end

    // Stage 4: classify where the foot of the perpendicular falls.
    region_t       region4_reg;
    logic          degen4_reg;
    logic [PW-1:0] t4_reg;
    logic [PW-1:0] ww4_reg;
    logic [PW-1:0] len4_reg;
    logic [PW-1:0] end4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            degen4_reg <= (len3_reg == '0);
            t4_reg     <= t3_reg;
            ww4_reg    <= ww3_reg;
            len4_reg   <= len3_reg;
            if (len3_reg == '0 || t3_reg[PW-1])
            begin
                region4_reg <= REGION_BEFORE;
                end4_reg    <= ww3_reg;
            end
            else if (t3_reg > $signed(len3_reg))
            begin
                region4_reg <= REGION_BEYOND;
                end4_reg    <= ee3_reg;
            end
            else
            begin
                region4_reg <= REGION_INSIDE;
                end4_reg    <= ww3_reg;
            end
        end
    end

    // Stage 5: partial products of ww*len and t*t on half words.
    logic [PW-1:0] pa5_reg [4];
    logic [PW-1:0] pb5_reg [4];
    region_t       region5_reg;
    logic          degen5_reg;
    logic [PW-1:0] len5_reg;
    logic [PW-1:0] end5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            pa5_reg[0] <= PW'(ww4_reg[H-1:0])  * PW'(len4_reg[H-1:0]);
            pa5_reg[1] <= PW'(ww4_reg[H-1:0])  * PW'(len4_reg[PW-1:H]);
            pa5_reg[2] <= PW'(ww4_reg[PW-1:H]) * PW'(len4_reg[H-1:0]);
            pa5_reg[3] <= PW'(ww4_reg[PW-1:H]) * PW'(len4_reg[PW-1:H]);
            pb5_reg[0] <= PW'(t4_reg[H-1:0])   * PW'(t4_reg[H-1:0]);
            pb5_reg[1] <= PW'(t4_reg[H-1:0])   * PW'(t4_reg[PW-1:H]);
            pb5_reg[2] <= PW'(t4_reg[PW-1:H])  * PW'(t4_reg[H-1:0]);
            pb5_reg[3] <= PW'(t4_reg[PW-1:H])  * PW'(t4_reg[PW-1:H]);
            region5_reg <= region4_reg;
            degen5_reg  <= degen4_reg;
            len5_reg    <= len4_reg;
            end5_reg    <= end4_reg;
        end
    end

    // Stage 6: numerator and denominator of the squared distance.
    logic [NW-1:0] prod_a;
    logic [NW-1:0] prod_b;

    always_comb
    begin
        prod_a = NW'(pa5_reg[0]) + (NW'(pa5_reg[1]) << H) + (NW'(pa5_reg[2]) << H)
               + (NW'(pa5_reg[3]) << (2 * H));
        prod_b = NW'(pb5_reg[0]) + (NW'(pb5_reg[1]) << H) + (NW'(pb5_reg[2]) << H)
               + (NW'(pb5_reg[3]) << (2 * H));
    end

    logic [NW-1:0]     rem_reg    [SQRT_STEPS+1];
    logic [EW-1:0]     acc_reg    [SQRT_STEPS+1];
    logic [PW-1:0]     den_reg    [SQRT_STEPS+1];
    logic [DIST_W-1:0] root_reg   [SQRT_STEPS+1];
    region_t           region_pipe[SQRT_STEPS+1];
    logic              degen_pipe [SQRT_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            if (region5_reg == REGION_INSIDE)
            begin
                rem_reg[0] <= (prod_a >= prod_b) ? prod_a - prod_b : '0;
                den_reg[0] <= len5_reg;
            end
            else
            begin
                rem_reg[0] <= NW'(end5_reg);
                den_reg[0] <= PW'(1);
            end
            acc_reg[0]     <= '0;
            root_reg[0]    <= '0;
            region_pipe[0] <= region5_reg;
            degen_pipe[0]  <= degen5_reg;
        end
    end

    // Root stages: rem holds num - k*k*den and acc holds k*den, so trying
    // the next bit costs only shifted adds and one compare.
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_root
        localparam int BIT = SQRT_STEPS - 1 - j;
        logic [EW-1:0] delta;

        assign delta = (acc_reg[j] << (BIT + 1)) + (EW'(den_reg[j]) << (2 * BIT));

        always_ff @(posedge clk)
        begin
            if (adv[6+j])
            begin
                if (delta <= EW'(rem_reg[j]))
                begin
                    rem_reg[j+1]  <= rem_reg[j] - NW'(delta);
                    acc_reg[j+1]  <= acc_reg[j] + (EW'(den_reg[j]) << BIT);
                    root_reg[j+1] <= root_reg[j] | (DIST_W'(1) << BIT);
                end
                else
                begin
                    rem_reg[j+1]  <= rem_reg[j];
                    acc_reg[j+1]  <= acc_reg[j];
                    root_reg[j+1] <= root_reg[j];
                end
                den_reg[j+1]     <= den_reg[j];
                region_pipe[j+1] <= region_pipe[j];
                degen_pipe[j+1]  <= degen_pipe[j];
            end
        end
    end

    assign result_valid = vld_reg[NSTG-1];
    assign distance     = root_reg[SQRT_STEPS];
    assign region       = region_pipe[SQRT_STEPS];
    assign degenerate   = degen_pipe[SQRT_STEPS];

endmodule
